@@ hw/rtl/b32e_pkg.sv @@
// Shared types, constants and the alphabet for the Bech32 address encoder.
// No dependencies; used by the checksum unit, the top level and the testbench.
package b32e_pkg;

    localparam int unsigned MAX_PREFIX_CHARS = 8;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_ENABLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SYMBOL   = 2'd3;

    localparam logic [63:0] RST_PREFIX_CHARS  = 64'd25442;
    localparam logic [3:0]  RST_PREFIX_LENGTH = 4'd2;

    localparam logic [6:0] SEP_CHAR = 7'h31;   // '1'

    // first character sits in the top byte of the string literal
    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    localparam logic [29:0] POLY_GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    typedef enum logic [2:0] {
        POLY_HOLD,
        POLY_INIT,
        POLY_STEP,
        POLY_XOR1,
        POLY_SHIFT
    } t_poly_op;

    typedef struct packed {
        t_poly_op    op;
        logic [4:0]  sym;
    } t_poly_cmd;

    function automatic logic [6:0] b32e_char(input logic [4:0] sym);
        logic [7:0] pos;
        pos = {~sym, 3'b000};
        return ALPHABET[pos +: 7];
    endfunction

endpackage

@@ hw/rtl/b32e_byte_if.sv @@
// Input channel of the Bech32 encoder: one payload byte per beat.
// No dependencies.
interface b32e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       end_of_message;

    modport source (output valid, output payload_byte, output end_of_message, input ready);
    modport sink   (input valid, input payload_byte, input end_of_message, output ready);
endinterface

@@ hw/rtl/b32e_char_if.sv @@
// Output channel of the Bech32 encoder: one ASCII character per beat.
// No dependencies.
interface b32e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ hw/rtl/b32e_poly.sv @@
// BIP173 polymod accumulator: one 5-bit symbol step per POLY_STEP command, plus init, xor and shift.
// Depends on b32e_pkg.
module b32e_poly (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b32e_pkg::t_poly_cmd i_cmd,
    output logic [4:0]         o_top_sym
);

    logic [29:0] r_acc;
    logic [29:0] n_acc;
    logic [29:0] w_step;

    always_comb begin
        w_step = {r_acc[24:0], 5'b00000} ^ {25'd0, i_cmd.sym};
        for (int k = 0; k < 5; k++) begin
            if (r_acc[25+k]) begin
                w_step = w_step ^ b32e_pkg::POLY_GEN[k];
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        unique case (i_cmd.op)
            b32e_pkg::POLY_INIT:  n_acc = 30'd1;
            b32e_pkg::POLY_STEP:  n_acc = w_step;
            b32e_pkg::POLY_XOR1:  n_acc = r_acc ^ 30'd1;
            // checksum read-out: top symbol leaves, five zeros come in
            b32e_pkg::POLY_SHIFT: n_acc = {r_acc[24:0], 5'b00000};
            default:              n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 30'd1;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_top_sym = r_acc[29:25];

endmodule

@@ hw/rtl/bech32_address_encoder_top.sv @@
// Top level of the Bech32 (BIP173) address encoder: sequencer, bit regrouping,
// output register. Depends on b32e_pkg, b32e_byte_if, b32e_char_if, b32e_poly.
//
// Usage:
//   i_byte takes one payload byte per beat with end_of_message on the final
//   byte. o_char gives one ASCII character per beat; last_char marks the sixth
//   checksum character. Configuration (prefix characters, prefix length, lead
//   enable, lead symbol) must be written via i_cfg_we/i_cfg_idx/i_cfg_wdata
//   between messages; the block does not enforce this. It reads them while
//   a message's prefix and lead symbol go out. One byte is worked on at a
//   time; i_byte.ready is high only while the sequencer waits for a byte. A
//   following byte is split into 5-bit symbols, all going through the single
//   polymod step unit. A first byte is preceded by the prefix characters, a
//   zero step, the low halves of the prefix and the separator; the lead state
//   is passed whether or not the lead symbol is enabled. A last byte adds an
//   optional pad symbol, six zero steps, one xor and six checksum characters.
//   Results leave through one output register, so a byte can be accepted while
//   a character still waits; a stalled receiver holds the sequencer at the
//   next character. Reset (synchronous) clears the message state and loads
//   the prefix "bc", length 2, lead enabled, lead symbol 0.
module bech32_address_encoder_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    b32e_byte_if.sink                              i_byte,
    b32e_char_if.source                            o_char,
    input  logic                                   i_cfg_we,
    input  logic [b32e_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [b32e_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREFIX = 4'd1;
    localparam logic [3:0] S_PZERO  = 4'd2;
    localparam logic [3:0] S_PEXP   = 4'd3;
    localparam logic [3:0] S_SEP    = 4'd4;
    localparam logic [3:0] S_LEAD   = 4'd5;
    localparam logic [3:0] S_LOAD   = 4'd6;
    localparam logic [3:0] S_SYMS   = 4'd7;
    localparam logic [3:0] S_PAD    = 4'd8;
    localparam logic [3:0] S_ZEROS  = 4'd9;
    localparam logic [3:0] S_XOR    = 4'd10;
    localparam logic [3:0] S_CSUM   = 4'd11;

    localparam logic [2:0] LAST_SIX = 3'd5;

    // configuration
    logic [63:0] r_prefix;
    logic [3:0]  r_plen;
    logic        r_lead_en;
    logic [4:0]  r_lead_sym;

    // sequencer and regrouping state
    logic [3:0]  r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    logic [11:0] r_buf, n_buf;
    logic [3:0]  r_held, n_held;
    logic        r_in_msg, n_in_msg;
    logic        r_last, n_last;
    logic [7:0]  r_byte;

    // output register
    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        r_out_last;

    logic        w_accept;
    logic        w_slot;
    logic        w_emit;
    logic [6:0]  w_emit_char;
    logic        w_emit_last;
    logic [3:0]  w_plen;
    logic [6:0]  w_pchar;
    logic        w_pfx_last;
    logic [3:0]  w_held_sub;
    logic [4:0]  w_sym_cur;
    logic [11:0] w_mask_sub;
    logic [11:0] w_mask_held;
    logic [4:0]  w_pad_sym;
    logic [4:0]  w_top_sym;
    b32e_pkg::t_poly_cmd w_cmd;

    assign i_byte.ready = (r_state == S_IDLE);
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_slot       = !r_out_valid || o_char.ready;

    assign w_plen     = (r_plen > 4'(b32e_pkg::MAX_PREFIX_CHARS)) ?
                        4'(b32e_pkg::MAX_PREFIX_CHARS) : r_plen;
    assign w_pchar    = r_prefix[{r_idx, 3'b000} +: 7];
    assign w_pfx_last = ({1'b0, r_idx} == (w_plen - 4'd1));
    assign w_held_sub = r_held - 4'd5;
    assign w_sym_cur  = 5'(r_buf >> w_held_sub);
    assign w_mask_sub = ~(12'hFFF << w_held_sub);
    assign w_mask_held = ~(12'hFFF << r_held);
    // leftover bits move to the top of the pad symbol
    assign w_pad_sym  = 5'(r_buf[4:0] << (3'd5 - r_held[2:0]));

    b32e_poly u_poly (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_top_sym (w_top_sym)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_buf       = r_buf;
        n_held      = r_held;
        n_in_msg    = r_in_msg;
        n_last      = r_last;
        w_emit      = 1'b0;
        w_emit_char = 7'd0;
        w_emit_last = 1'b0;
        w_cmd.op    = b32e_pkg::POLY_HOLD;
        w_cmd.sym   = 5'd0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_byte.end_of_message;
                    if (!r_in_msg) begin
                        n_in_msg = 1'b1;
                        n_buf    = 12'd0;
                        n_held   = 4'd0;
                        n_idx    = 3'd0;
                        w_cmd.op = b32e_pkg::POLY_INIT;
                        n_state  = S_PREFIX;
                    end else begin
                        n_buf   = {r_buf[3:0], i_byte.payload_byte};
                        n_held  = r_held + 4'd8;
                        n_state = S_SYMS;
                    end
                end
            end
            S_PREFIX: begin
                if (w_plen == 4'd0) begin
                    n_state = S_PZERO;
                end else if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = w_pchar;
                    w_cmd.op    = b32e_pkg::POLY_STEP;
                    w_cmd.sym   = {3'b000, w_pchar[6:5]};
                    if (w_pfx_last) begin
                        n_idx   = 3'd0;
                        n_state = S_PZERO;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            S_PZERO: begin
                w_cmd.op = b32e_pkg::POLY_STEP;
                n_state  = (w_plen == 4'd0) ? S_SEP : S_PEXP;
            end
            S_PEXP: begin
                w_cmd.op  = b32e_pkg::POLY_STEP;
                w_cmd.sym = w_pchar[4:0];
                if (w_pfx_last) begin
                    n_idx   = 3'd0;
                    n_state = S_SEP;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_SEP: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = b32e_pkg::SEP_CHAR;
                    n_state     = S_LEAD;
                end
            end
            S_LEAD: begin
                if (!r_lead_en) begin
                    n_state = S_LOAD;
                end else if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = b32e_pkg::b32e_char(r_lead_sym);
                    w_cmd.op    = b32e_pkg::POLY_STEP;
                    w_cmd.sym   = r_lead_sym;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                n_buf   = {r_buf[3:0], r_byte};
                n_held  = 4'd8;
                n_state = S_SYMS;
            end
            S_SYMS: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = b32e_pkg::b32e_char(w_sym_cur);
                    w_cmd.op    = b32e_pkg::POLY_STEP;
                    w_cmd.sym   = w_sym_cur;
                    n_held      = w_held_sub;
                    if (w_held_sub < 4'd5) begin
                        n_buf = r_buf & w_mask_sub;
                        n_idx = 3'd0;
                        if (!r_last) begin
                            n_state = S_IDLE;
                        end else if (w_held_sub != 4'd0) begin
                            n_state = S_PAD;
                        end else begin
                            n_state = S_ZEROS;
                        end
                    end
                end
            end
            S_PAD: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = b32e_pkg::b32e_char(w_pad_sym);
                    w_cmd.op    = b32e_pkg::POLY_STEP;
                    w_cmd.sym   = w_pad_sym;
                    n_state     = S_ZEROS;
                end
            end
            S_ZEROS: begin
                w_cmd.op = b32e_pkg::POLY_STEP;
                if (r_idx == LAST_SIX) begin
                    n_idx   = 3'd0;
                    n_state = S_XOR;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_XOR: begin
                w_cmd.op = b32e_pkg::POLY_XOR1;
                n_state  = S_CSUM;
            end
            S_CSUM: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = b32e_pkg::b32e_char(w_top_sym);
                    w_emit_last = (r_idx == LAST_SIX);
                    w_cmd.op    = b32e_pkg::POLY_SHIFT;
                    if (r_idx == LAST_SIX) begin
                        n_idx    = 3'd0;
                        n_buf    = 12'd0;
                        n_held   = 4'd0;
                        n_in_msg = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 3'd0;
            r_buf       <= 12'd0;
            r_held      <= 4'd0;
            r_in_msg    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prefix    <= b32e_pkg::RST_PREFIX_CHARS;
            r_plen      <= b32e_pkg::RST_PREFIX_LENGTH;
            r_lead_en   <= 1'b1;
            r_lead_sym  <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_buf    <= n_buf;
            r_held   <= n_held;
            r_in_msg <= n_in_msg;
            r_last   <= n_last;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    b32e_pkg::CFG_PREFIX_CHARS:  r_prefix   <= i_cfg_wdata;
                    b32e_pkg::CFG_PREFIX_LENGTH: r_plen     <= i_cfg_wdata[3:0];
                    b32e_pkg::CFG_LEAD_ENABLE:   r_lead_en  <= i_cfg_wdata[0];
                    b32e_pkg::CFG_LEAD_SYMBOL:   r_lead_sym <= i_cfg_wdata[4:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte.payload_byte;
        end
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
        end
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.char_code = r_out_char;
    assign o_char.last_char = r_out_last;

    // between bytes fewer than five bits wait, and only those bits may be set
    a_idle_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_held < 4'd5))
        else $error("leftover bit count too large between bytes");

    a_idle_buf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_buf & ~w_mask_held) == 12'd0))
        else $error("stale bits above the leftover count");

    a_no_msg_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_in_msg) |-> (r_held == 4'd0))
        else $error("leftover bits outside a message");

    a_cont_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_in_msg) |=> (r_state == S_SYMS && r_held >= 4'd8))
        else $error("continuing beat did not go straight to symbol output");

endmodule

@@ tb/tb_bech32_address_encoder_top.sv @@
// Self-checking testbench for bech32_address_encoder_top: predicts every Bech32 character
// from the accepted bytes and the register settings, and compares the streamed characters.
// Depends on b32e_pkg, b32e_byte_if, b32e_char_if and the encoder RTL.
module tb_bech32_address_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned TOTAL_BYTES = 110;
    localparam int unsigned MAX_SHOWN   = 10;

    localparam logic [0:31][7:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };
    localparam logic [6:0] SEPARATOR = 7'h31;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char_due;

    class bech32_char_scoreboard;
        logic [63:0] cfg_prefix   = b32e_pkg::RST_PREFIX_CHARS;
        logic [3:0]  cfg_len      = b32e_pkg::RST_PREFIX_LENGTH;
        logic        cfg_lead_en  = 1'b1;
        logic [4:0]  cfg_lead_sym = 5'd0;

        logic [11:0] bitbuf = '0;
        int unsigned held   = 0;
        logic [29:0] acc    = 30'd1;
        logic        open   = 1'b0;

        t_char_due   chars_due[$];
        int unsigned mismatches = 0;

        function void set_reg(logic [b32e_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                b32e_pkg::CFG_PREFIX_CHARS:  cfg_prefix   = data;
                b32e_pkg::CFG_PREFIX_LENGTH: cfg_len      = data[3:0];
                b32e_pkg::CFG_LEAD_ENABLE:   cfg_lead_en  = data[0];
                b32e_pkg::CFG_LEAD_SYMBOL:   cfg_lead_sym = data[4:0];
                default: ;
            endcase
        endfunction

        function void polymod(logic [4:0] s);
            logic [4:0]  top;
            logic [29:0] nxt;
            top = acc[29:25];
            nxt = {acc[24:0], 5'b0} ^ {25'b0, s};
            for (int k = 0; k < 5; k++) begin
                if (top[k]) nxt ^= GEN[k];
            end
            acc = nxt;
        endfunction

        function void push_char(logic [6:0] code, logic last);
            t_char_due c;
            c.code = code;
            c.last = last;
            chars_due = {chars_due, c};
        endfunction

        function void push_symbol(logic [4:0] s);
            push_char(CHARSET[s][6:0], 1'b0);
            polymod(s);
        endfunction

        function void take_byte(logic [7:0] b, logic eom);
            int unsigned plen;
            logic [6:0]  c;
            if (!open) begin
                plen = (cfg_len > b32e_pkg::MAX_PREFIX_CHARS) ?
                       b32e_pkg::MAX_PREFIX_CHARS : cfg_len;
                acc = 30'd1;
                // high halves of the prefix go in alongside the characters themselves
                for (int i = 0; i < plen; i++) begin
                    c = cfg_prefix[8*i +: 7];
                    push_char(c, 1'b0);
                    polymod({3'b0, c[6:5]});
                end
                polymod(5'd0);
                for (int i = 0; i < plen; i++) begin
                    c = cfg_prefix[8*i +: 7];
                    polymod(c[4:0]);
                end
                push_char(SEPARATOR, 1'b0);
                if (cfg_lead_en) push_symbol(cfg_lead_sym);
                bitbuf = '0;
                held   = 0;
                open   = 1'b1;
            end
            bitbuf = {bitbuf[3:0], b};
            held  += 8;
            while (held >= 5) begin
                held -= 5;
                push_symbol(5'(bitbuf >> held));
            end
            bitbuf &= (12'd1 << held) - 12'd1;
            if (eom) begin
                if (held > 0) push_symbol(5'(bitbuf << (5 - held)));
                repeat (6) polymod(5'd0);
                acc ^= 30'd1;
                for (int i = 0; i < 6; i++) begin
                    push_char(CHARSET[acc[5*(5-i) +: 5]][6:0], i == 5);
                end
                bitbuf = '0;
                held   = 0;
                acc    = 30'd1;
                open   = 1'b0;
            end
        endfunction

        function void match_char(logic [6:0] code, logic last);
            t_char_due c;
            if (chars_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected char: code %02h last %0b", code, last);
                return;
            end
            c = chars_due.pop_front();
            if (c.code !== code || c.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("char mismatch: expected code %02h last %0b, got code %02h last %0b",
                             c.code, c.last, code, last);
            end
        endfunction

        function int unsigned pending();
            return chars_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [b32e_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [b32e_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    b32e_byte_if byte_ch ();
    b32e_char_if char_ch ();

    bech32_address_encoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_ch),
        .o_char      (char_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    bech32_char_scoreboard sb = new;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned bytes_sent    = 0;

    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // beat monitors
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
            sb.take_byte(byte_ch.payload_byte, byte_ch.end_of_message);
        if (i_rst_n === 1'b1 && char_ch.valid === 1'b1 && char_ch.ready === 1'b1)
            sb.match_char(char_ch.char_code, char_ch.last_char);
    end

    initial begin
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            char_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.payload_byte   <= b;
        byte_ch.end_of_message <= eom;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // waits on the clock before it checks, so the last accepted beat has reached the scoreboard
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_config(input logic [63:0] pfx, input logic [3:0] len,
                                input logic en, input logic [4:0] sym);
        logic [b32e_pkg::CFG_IDX_W-1:0] idxs [4];
        logic [63:0]                    vals [4];
        idxs = '{b32e_pkg::CFG_PREFIX_CHARS, b32e_pkg::CFG_PREFIX_LENGTH,
                 b32e_pkg::CFG_LEAD_ENABLE, b32e_pkg::CFG_LEAD_SYMBOL};
        vals = '{pfx, 64'(len), 64'(en), 64'(sym)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            sb.set_reg(idxs[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0]  msg[$];
        logic [3:0]  len;
        int unsigned n_msgs;
        int unsigned n_bytes;
        int unsigned sel;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= '0;
        i_cfg_wdata            <= '0;
        byte_ch.valid          <= 1'b0;
        byte_ch.payload_byte   <= '0;
        byte_ch.end_of_message <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 59;

        // directed: reset settings, single-byte message, byte extremes
        send_message('{8'h00});
        send_message('{8'hFF, 8'h00, 8'hA5});
        wait_drained();

        // prefix bytes with bit 7 set, full length, no lead symbol
        write_config(64'hFFFE_8180_7F01_C2E1, 4'd8, 1'b0, 5'd0);
        send_message('{8'hFF});
        send_message('{8'h5A, 8'hC3, 8'h0F, 8'hF0, 8'h81});
        wait_drained();

        // empty prefix, top lead symbol
        write_config(64'h0000_0000_0000_6274, 4'd0, 1'b1, 5'd31);
        send_message('{8'h80, 8'h7F});
        wait_drained();

        // length beyond eight saturates
        write_config({$urandom, $urandom}, 4'd15, 1'b1, 5'd16);
        send_message('{8'h01});
        wait_drained();

        write_config(64'h61, 4'd1, 1'b0, 5'd0);
        send_message('{8'h33, 8'hCC});
        wait_drained();

        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent < TOTAL_BYTES / 3) begin
                send_idle_pct = 11;
                recv_idle_pct = 59;
            end else if (bytes_sent < 2 * TOTAL_BYTES / 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            sel = $urandom_range(9);
            if (sel == 0)      len = 4'd0;
            else if (sel == 1) len = 4'($urandom_range(15, 9));
            else               len = 4'($urandom_range(8, 1));
            write_config({$urandom, $urandom}, len, 1'($urandom), 5'($urandom));

            n_msgs = $urandom_range(4, 1);
            repeat (n_msgs) begin
                // mostly short strings, now and then a long one
                n_bytes = ($urandom_range(7) == 0) ? $urandom_range(24, 9)
                                                   : $urandom_range(6, 1);
                if (n_bytes > TOTAL_BYTES - bytes_sent)
                    n_bytes = TOTAL_BYTES - bytes_sent;
                msg.delete();
                repeat (n_bytes) msg = {msg, 8'($urandom)};
                if (n_bytes != 0) send_message(msg);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
